// ===== hw/rtl/sapq_pkg.sv =====
// ----------------------------------------------------------------------------
// sapq_pkg
// Shared types and default sizes for the sorted array priority queue.
// ----------------------------------------------------------------------------
package sapq_pkg;

  localparam int unsigned DefDepth       = 128;
  localparam int unsigned DefPayloadBits = 32;
  localparam int unsigned DefPrioBits    = 8;

  localparam int unsigned ActionBits = 2;

  typedef enum logic [ActionBits-1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_PEEK   = 2'd2
  } action_e;

  // Operation applied to every cell of the chain at once.
  typedef struct packed {
    logic insert;
    logic remove;
  } cell_ctrl_t;

endpackage

// ===== hw/rtl/sapq_cell.sv =====
// ----------------------------------------------------------------------------
// sapq_cell
// One slot of the sorted chain: holds an entry and shifts toward its
// neighbors on insert or remove.
// ----------------------------------------------------------------------------
module sapq_cell import sapq_pkg::*; #(
  parameter int unsigned PayloadBits = DefPayloadBits,
  parameter int unsigned PrioBits    = DefPrioBits
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cell_ctrl_t             ctrl_i,
  input  logic [PrioBits-1:0]    new_prio_i,
  input  logic [PayloadBits-1:0] new_payload_i,
  input  logic                   left_keep_i,
  input  logic                   left_valid_i,
  input  logic [PrioBits-1:0]    left_prio_i,
  input  logic [PayloadBits-1:0] left_payload_i,
  input  logic                   right_valid_i,
  input  logic [PrioBits-1:0]    right_prio_i,
  input  logic [PayloadBits-1:0] right_payload_i,
  output logic                   keep_o,
  output logic                   valid_o,
  output logic [PrioBits-1:0]    prio_o,
  output logic [PayloadBits-1:0] payload_o,
  output logic                   valid_d_o,
  output logic [PrioBits-1:0]    prio_d_o,
  output logic [PayloadBits-1:0] payload_d_o
);

  logic                   valid_q, valid_d;
  logic [PrioBits-1:0]    prio_q, prio_d;
  logic [PayloadBits-1:0] payload_q, payload_d;

  // An entry of equal or higher priority stays ahead of the new one.
  assign keep_o = valid_q && (prio_q >= new_prio_i);

  always_comb begin
    valid_d   = valid_q;
    prio_d    = prio_q;
    payload_d = payload_q;
    if (ctrl_i.insert && !keep_o) begin
      if (left_keep_i) begin
        valid_d   = 1'b1;
        prio_d    = new_prio_i;
        payload_d = new_payload_i;
      end else begin
        valid_d   = left_valid_i;
        prio_d    = left_prio_i;
        payload_d = left_payload_i;
      end
    end else if (ctrl_i.remove) begin
      valid_d   = right_valid_i;
      prio_d    = right_prio_i;
      payload_d = right_payload_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prio_q    <= prio_d;
    payload_q <= payload_d;
  end

  assign valid_o     = valid_q;
  assign prio_o      = prio_q;
  assign payload_o   = payload_q;
  assign valid_d_o   = valid_d;
  assign prio_d_o    = prio_d;
  assign payload_d_o = payload_d;

endmodule

// ===== hw/rtl/sorted_array_priority_queue.sv =====
// ----------------------------------------------------------------------------
// sorted_array_priority_queue
// Bounded priority queue built as a chain of cells kept sorted by priority,
// head in cell 0, equal priorities leaving in arrival order.
//
//   Channel  Direction  Handshake              Word
//   in       input      in_valid_i/in_ready_o  action, payload, priority_req
//   out      output     out_valid_o/out_ready_i ok, head, count, full, empty
//
// All cells update in parallel at the accepting edge and the result word
// is registered at the same edge.
// The input is taken whenever the result register is empty or being drained,
// so one word per cycle is sustained while the output keeps up.
// Reset clears the occupancy bits and the count; entry data needs none.
// ----------------------------------------------------------------------------
module sorted_array_priority_queue import sapq_pkg::*; #(
  parameter int unsigned Depth       = DefDepth,
  parameter int unsigned PayloadBits = DefPayloadBits,
  parameter int unsigned PrioBits    = DefPrioBits,
  localparam int unsigned CntBits    = $clog2(Depth + 1)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [ActionBits-1:0]  action_i,
  input  logic [PayloadBits-1:0] payload_i,
  input  logic [PrioBits-1:0]    priority_req_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic                   ok_o,
  output logic [PayloadBits-1:0] head_payload_o,
  output logic [PrioBits-1:0]    head_priority_o,
  output logic [CntBits-1:0]     count_o,
  output logic                   is_full_o,
  output logic                   is_empty_o
);

  localparam logic [CntBits-1:0] FullCount = CntBits'(Depth);

  logic                   in_fire;
  logic                   full, empty;
  logic                   ok_d;
  cell_ctrl_t             ctrl;
  logic [CntBits-1:0]     count_q, count_d;

  logic                   out_valid_q, out_valid_d;
  logic                   ok_q;
  logic [PayloadBits-1:0] head_payload_q;
  logic [PrioBits-1:0]    head_prio_q;
  logic [CntBits-1:0]     out_count_q;

  logic [Depth-1:0]       keep_w, valid_w, valid_dw;
  logic [PrioBits-1:0]    prio_w    [Depth];
  logic [PayloadBits-1:0] payload_w [Depth];
  logic [PrioBits-1:0]    prio_dw   [Depth];
  logic [PayloadBits-1:0] payload_dw[Depth];

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign full       = (count_q == FullCount);
  assign empty      = (count_q == '0);

  always_comb begin
    ok_d        = 1'b0;
    ctrl.insert = 1'b0;
    ctrl.remove = 1'b0;
    count_d     = count_q;
    unique case (action_e'(action_i))
      ACT_INSERT: begin
        ok_d        = !full;
        ctrl.insert = in_fire && !full;
      end
      ACT_REMOVE: begin
        ok_d        = !empty;
        ctrl.remove = in_fire && !empty;
      end
      ACT_PEEK: begin
        ok_d = !empty;
      end
      default: begin
        ok_d = 1'b0;
      end
    endcase
    if (ctrl.insert) begin
      count_d = count_q + CntBits'(1);
    end else if (ctrl.remove) begin
      count_d = count_q - CntBits'(1);
    end
  end

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    logic                   left_keep, left_valid, right_valid;
    logic [PrioBits-1:0]    left_prio, right_prio;
    logic [PayloadBits-1:0] left_payload, right_payload;

    if (i == 0) begin : g_first
      assign left_keep    = 1'b1;
      assign left_valid   = 1'b0;
      assign left_prio    = '0;
      assign left_payload = '0;
    end else begin : g_inner_left
      assign left_keep    = keep_w[i-1];
      assign left_valid   = valid_w[i-1];
      assign left_prio    = prio_w[i-1];
      assign left_payload = payload_w[i-1];
    end

    if (i == Depth - 1) begin : g_last
      assign right_valid   = 1'b0;
      assign right_prio    = '0;
      assign right_payload = '0;
    end else begin : g_inner_right
      assign right_valid   = valid_w[i+1];
      assign right_prio    = prio_w[i+1];
      assign right_payload = payload_w[i+1];
    end

    sapq_cell #(
      .PayloadBits(PayloadBits),
      .PrioBits   (PrioBits)
    ) u_cell (
      .clk_i          (clk_i),
      .rst_ni         (rst_ni),
      .ctrl_i         (ctrl),
      .new_prio_i     (priority_req_i),
      .new_payload_i  (payload_i),
      .left_keep_i    (left_keep),
      .left_valid_i   (left_valid),
      .left_prio_i    (left_prio),
      .left_payload_i (left_payload),
      .right_valid_i  (right_valid),
      .right_prio_i   (right_prio),
      .right_payload_i(right_payload),
      .keep_o         (keep_w[i]),
      .valid_o        (valid_w[i]),
      .prio_o         (prio_w[i]),
      .payload_o      (payload_w[i]),
      .valid_d_o      (valid_dw[i]),
      .prio_d_o       (prio_dw[i]),
      .payload_d_o    (payload_dw[i])
    );
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // The result word sees the head as it will be after this operation.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      ok_q           <= ok_d;
      head_payload_q <= valid_dw[0] ? payload_dw[0] : '0;
      head_prio_q    <= valid_dw[0] ? prio_dw[0] : '0;
      out_count_q    <= count_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign ok_o            = ok_q;
  assign head_payload_o  = head_payload_q;
  assign head_priority_o = head_prio_q;
  assign count_o         = out_count_q;
  assign is_full_o       = (out_count_q == FullCount);
  assign is_empty_o      = (out_count_q == '0);

  a_count_matches_cells : assert property (@(posedge clk_i) disable iff (!rst_ni)
    CntBits'($countones(valid_w)) == count_q)
    else $error("fill count disagrees with occupied cells");

  a_head_sorted : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_w[1] |-> (prio_w[0] >= prio_w[1]))
    else $error("head priority below second entry");

  a_remove_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.remove |=> (count_q == $past(count_q) - CntBits'(1)))
    else $error("remove did not decrement the count");

  a_empty_head_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (count_d == '0)) |=> (head_prio_q == '0 && !valid_w[0]))
    else $error("empty queue reports a head entry");

endmodule
